// ===== hw/rtl/nsb_pkg.sv =====
package nsb_pkg;

	localparam int DIGIT_BASE  = 10;
	localparam int TIME_W      = 6;
	localparam int HOURS_W     = 5;
	localparam int BCD_W       = 4;
	localparam int TUBES       = 4;
	localparam int PHASE_W     = 4;

	typedef enum logic [1:0] {
		TUBE_MIN_ONES  = 2'd0,
		TUBE_MIN_TENS  = 2'd1,
		TUBE_HOUR_ONES = 2'd2,
		TUBE_HOUR_TENS = 2'd3
	} tube_t;

	typedef struct packed {
		logic [TIME_W-1:0]  minutes;
		logic [HOURS_W-1:0] hours;
		logic               burn;
		tube_t              tube;
		logic [PHASE_W-1:0] phase;
	} stage_t;

	typedef struct packed {
		logic [2:0]       tens;
		logic [BCD_W-1:0] ones;
	} split_t;

	function automatic split_t digit_split(input logic [TIME_W-1:0] v);
		split_t     r;
		logic [TIME_W-1:0] prod;
		r.tens = 3'd0;
		for (int i = 1; i <= 6; i++) begin
			if (v >= TIME_W'(i * DIGIT_BASE)) begin
				r.tens = 3'(i);
			end
		end
		prod = TIME_W'(r.tens) * TIME_W'(DIGIT_BASE);
		r.ones = BCD_W'(v - prod);
		return r;
	endfunction

endpackage

// ===== hw/rtl/nsb_if.sv =====
interface nsb_tick_if;
	logic                        valid;
	logic                        ready;
	logic [nsb_pkg::TIME_W-1:0]  minutes_shown;
	logic [nsb_pkg::HOURS_W-1:0] hours_shown;
	logic                        burn_mode;

	modport source(output valid, minutes_shown, hours_shown, burn_mode, input ready);
	modport sink(input valid, minutes_shown, hours_shown, burn_mode, output ready);
endinterface

interface nsb_tube_if;
	logic                       valid;
	logic                       ready;
	logic [nsb_pkg::TUBES-1:0]  anode_enable;
	logic [nsb_pkg::BCD_W-1:0]  bcd_digit;
	logic                       seconds_lamp_off;

	modport source(output valid, anode_enable, bcd_digit, seconds_lamp_off, input ready);
	modport sink(input valid, anode_enable, bcd_digit, seconds_lamp_off, output ready);
endinterface

// ===== hw/rtl/nsb_sched.sv =====
module nsb_sched #(
	parameter int BURN_TICKS_PER_TUBE = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	nsb_tick_if.sink          tick,
	output nsb_pkg::stage_t   stage_s1,
	output logic              valid_s1,
	input  logic              ready_s1
);

	localparam logic [nsb_pkg::PHASE_W-1:0] PHASE_LAST =
		nsb_pkg::PHASE_W'(BURN_TICKS_PER_TUBE - 1);

	nsb_pkg::tube_t                scan_pos_q;
	nsb_pkg::tube_t                burn_tube_q;
	logic [nsb_pkg::PHASE_W-1:0]   burn_phase_q;
	logic                          accept;

	assign tick.ready = !valid_s1 || ready_s1;
	assign accept     = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pos_q   <= nsb_pkg::TUBE_MIN_ONES;
			burn_tube_q  <= nsb_pkg::TUBE_MIN_ONES;
			burn_phase_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (accept) begin
				if (!tick.burn_mode) begin
					scan_pos_q <= nsb_pkg::tube_t'(scan_pos_q + 2'd1);
				end
				if (burn_phase_q == PHASE_LAST) begin
					burn_phase_q <= '0;
					burn_tube_q  <= nsb_pkg::tube_t'(burn_tube_q + 2'd1);
				end else begin
					burn_phase_q <= burn_phase_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.minutes <= tick.minutes_shown;
			stage_s1.hours   <= tick.hours_shown;
			stage_s1.burn    <= tick.burn_mode;
			stage_s1.tube    <= tick.burn_mode ? burn_tube_q : scan_pos_q;
			stage_s1.phase   <= burn_phase_q;
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		burn_phase_q <= PHASE_LAST)
		else $error("burn phase out of range");

	a_scan_adv: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !tick.burn_mode |=> scan_pos_q == nsb_pkg::tube_t'($past(scan_pos_q) + 2'd1))
		else $error("scan position did not advance");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && !tick.burn_mode) |=> $stable(scan_pos_q))
		else $error("scan position moved without normal transaction");

	a_burn_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(burn_phase_q) && $stable(burn_tube_q))
		else $error("burn counter moved without transaction");

endmodule

// ===== hw/rtl/nsb_decode.sv =====
module nsb_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  nsb_pkg::stage_t  stage_s1,
	input  logic             valid_s1,
	output logic             ready_s1,
	nsb_tube_if.source       tube
);

	nsb_pkg::split_t              min_split;
	nsb_pkg::split_t              hour_split;
	logic [nsb_pkg::BCD_W-1:0]    digit;
	logic [nsb_pkg::BCD_W-1:0]    burn_digit;
	logic [nsb_pkg::TUBES-1:0]    anode;

	assign ready_s1 = !tube.valid || tube.ready;

	always_comb begin
		min_split  = nsb_pkg::digit_split(stage_s1.minutes);
		hour_split = nsb_pkg::digit_split(nsb_pkg::TIME_W'(stage_s1.hours));
		if (stage_s1.phase >= nsb_pkg::PHASE_W'(nsb_pkg::DIGIT_BASE)) begin
			burn_digit = stage_s1.phase - nsb_pkg::PHASE_W'(nsb_pkg::DIGIT_BASE);
		end else begin
			burn_digit = stage_s1.phase;
		end
		unique case (stage_s1.tube)
			nsb_pkg::TUBE_MIN_ONES:  digit = min_split.ones;
			nsb_pkg::TUBE_MIN_TENS:  digit = nsb_pkg::BCD_W'(min_split.tens);
			nsb_pkg::TUBE_HOUR_ONES: digit = hour_split.ones;
			nsb_pkg::TUBE_HOUR_TENS: digit = nsb_pkg::BCD_W'(hour_split.tens);
			default:                 digit = '0;
		endcase
		if (stage_s1.burn) begin
			digit = burn_digit;
		end
		anode = nsb_pkg::TUBES'(1) << stage_s1.tube;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tube.valid <= 1'b0;
		end else if (ready_s1) begin
			tube.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			tube.anode_enable     <= anode;
			tube.bcd_digit        <= digit;
			tube.seconds_lamp_off <= stage_s1.burn;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		tube.valid |-> $onehot(tube.anode_enable))
		else $error("anode not one-hot");

	a_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		tube.valid |-> tube.bcd_digit <= 4'd9)
		else $error("digit not BCD");

	a_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		ready_s1 && valid_s1 |=> tube.seconds_lamp_off == $past(stage_s1.burn))
		else $error("seconds lamp does not follow mode");

endmodule

// ===== hw/rtl/nixie_scan_with_burn_in.sv =====
// A transaction accepted from tick is registered first in stage_s1 and then in
// the tube output register, from which it is presented.
// Throughput: one tick per cycle; the input register and the result register
// each advance whenever the stage after them is empty or taken.
// Reset (arst_n low): scan position and burn counter go to zero,
// both pipeline stages are emptied.
module nixie_scan_with_burn_in #(
	parameter int BURN_TICKS_PER_TUBE = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	nsb_tick_if.sink     tick,
	nsb_tube_if.source   tube
);

	nsb_pkg::stage_t stage_s1;
	logic            valid_s1;
	logic            ready_s1;

	nsb_sched #(
		.BURN_TICKS_PER_TUBE(BURN_TICKS_PER_TUBE)
	) u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.stage_s1 (stage_s1),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1)
	);

	nsb_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s1 (stage_s1),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.tube     (tube)
	);

endmodule
